// File: src/sseg_pkg.sv
// ----------------------------------------------------------------------------
// sseg_pkg
// Shared types, command codes and tables for the seven-segment frame encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sseg_pkg;

  // Command codes
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_BRIGHT = 3'd1;
  localparam logic [2:0] CMD_DIGIT  = 3'd2;
  localparam logic [2:0] CMD_NUMBER = 3'd3;
  localparam logic [2:0] CMD_TENTHS = 3'd4;

  // Controller bytes
  localparam logic [7:0] BYTE_AUTO_INC = 8'h40;
  localparam logic [7:0] BYTE_ADDR     = 8'hC0;
  localparam logic [7:0] BYTE_BRIGHT   = 8'h88;
  localparam logic [7:0] BYTE_FIXED    = 8'h44;
  localparam logic [7:0] SEG_DOT       = 8'h80;
  localparam logic [7:0] SEG_MINUS     = 8'h40;
  localparam logic [7:0] SEG_E         = 8'h79;
  localparam logic [7:0] SEG_BLANK     = 8'h00;

  localparam logic [2:0] BRIGHT_MAX = 3'd7;
  localparam logic [2:0] POS_MAX    = 3'd3;
  localparam logic [3:0] DIGIT_MAX  = 4'd9;

  localparam int VAL_W = 14;
  localparam logic signed [16:0] COUNT_MAX  = 17'sd9999;
  localparam logic signed [16:0] TENTHS_MAX = 17'sd9999;
  localparam logic signed [16:0] TENTHS_MIN = -17'sd999;

  typedef enum logic [1:0] {
    K_ALL4,    // 0x40, 0xC0, then four segment bytes
    K_SINGLE,  // one byte framed alone
    K_DIGIT,   // one fixed-address digit write
    K_FOUR     // four fixed-address digit writes, places 0..3
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t     kind;
    logic [1:0]      place;
    logic [3:0][7:0] seg;
  } entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  typedef enum logic {
    FS_IDLE,
    FS_CONV
  } front_state_t;

  function automatic logic [7:0] seg_of_digit(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // k times the power of ten for digit step pw (0: thousands .. 2: tens)
  function automatic logic [VAL_W-1:0] pow_multiple(input logic [1:0] pw,
                                                    input logic [3:0] k);
    logic [VAL_W-1:0] p;
    case (pw)
      2'd0:    p = VAL_W'(1000);
      2'd1:    p = VAL_W'(100);
      default: p = VAL_W'(10);
    endcase
    return VAL_W'(p * VAL_W'(k));
  endfunction

endpackage

// File: src/sseg_front.sv
// ----------------------------------------------------------------------------
// sseg_front
// Accepts display commands, classifies them and converts counts and tenths
// values to segment bytes digit by digit, tens and ones last, busy meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sseg_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          cmd,
  input  logic [3:0]          brightness_level,
  input  logic [2:0]          position,
  input  logic [3:0]          digit_value,
  input  logic                dot,
  input  logic signed [16:0]  number,
  input  sseg_pkg::q_status_t q_status,
  output logic                push,
  output sseg_pkg::entry_t    push_data
);
  import sseg_pkg::*;

  front_state_t          state, state_next;
  logic [1:0]            cnt, cnt_next;
  logic [VAL_W-1:0]      rem, rem_next;
  logic [1:0][7:0]       seg_acc, seg_acc_next;
  logic                  neg, neg_next;
  logic                  tenths, tenths_next;

  logic [3:0]            d;
  logic [VAL_W-1:0]      rem_sub;
  logic [3:0]            ones;
  logic [16:0]           num_neg;
  logic [2:0]            lvl;

  // Digit at the current power of ten: the largest k with k*P not above rem
  always_comb begin
    d = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem >= pow_multiple(cnt, 4'(k))) d = 4'(k);
    end
    rem_sub = rem - pow_multiple(cnt, d);
    ones    = rem_sub[3:0];
  end

  assign num_neg = 17'(-number);
  assign lvl     = (brightness_level > 4'(BRIGHT_MAX)) ? BRIGHT_MAX : brightness_level[2:0];
  assign busy    = (state == FS_CONV) || q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
    cnt     <= cnt_next;
    rem     <= rem_next;
    seg_acc <= seg_acc_next;
    neg     <= neg_next;
    tenths  <= tenths_next;
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    rem_next     = rem;
    seg_acc_next = seg_acc;
    neg_next     = neg;
    tenths_next  = tenths;
    push         = 1'b0;
    push_data    = '0;

    unique case (state)
      FS_IDLE: begin
        if (start && !busy) begin
          cnt_next    = 2'd0;
          neg_next    = 1'b0;
          tenths_next = 1'b0;
          unique case (cmd)
            CMD_CLEAR: begin
              push           = 1'b1;
              push_data.kind = K_ALL4;
              push_data.seg  = {4{SEG_BLANK}};
            end
            CMD_BRIGHT: begin
              push             = 1'b1;
              push_data.kind   = K_SINGLE;
              push_data.seg[0] = BYTE_BRIGHT | {5'd0, lvl};
            end
            CMD_DIGIT: begin
              if (position <= POS_MAX && digit_value <= DIGIT_MAX) begin
                push             = 1'b1;
                push_data.kind   = K_DIGIT;
                push_data.place  = position[1:0];
                push_data.seg[0] = seg_of_digit(digit_value) | (dot ? SEG_DOT : 8'h00);
              end
            end
            CMD_NUMBER: begin
              state_next = FS_CONV;
              if (number < 0) begin
                rem_next = '0;
              end else if (number > COUNT_MAX) begin
                rem_next = VAL_W'(COUNT_MAX);
              end else begin
                rem_next = number[VAL_W-1:0];
              end
            end
            CMD_TENTHS: begin
              if (number > TENTHS_MAX || number < TENTHS_MIN) begin
                push           = 1'b1;
                push_data.kind = K_ALL4;
                push_data.seg  = {4{SEG_E}};
              end else begin
                state_next  = FS_CONV;
                tenths_next = 1'b1;
                if (number < 0) begin
                  neg_next = 1'b1;
                  rem_next = num_neg[VAL_W-1:0];
                end else begin
                  rem_next = number[VAL_W-1:0];
                end
              end
            end
            default: begin
              // unknown command: drop
            end
          endcase
        end
      end

      FS_CONV: begin
        rem_next = rem_sub;
        cnt_next = cnt + 2'd1;
        if (cnt != 2'd2) begin
          seg_acc_next[cnt[0]] = seg_of_digit(d);
        end else begin
          state_next       = FS_IDLE;
          push             = 1'b1;
          push_data.kind   = K_FOUR;
          push_data.seg[0] = neg ? SEG_MINUS : seg_acc[0];
          push_data.seg[1] = seg_acc[1];
          push_data.seg[2] = seg_of_digit(d) | (tenths ? SEG_DOT : 8'h00);
          push_data.seg[3] = seg_of_digit(ones);
        end
      end

      default: begin
        state_next = FS_IDLE;
      end
    endcase
  end

endmodule

// File: src/sseg_queue.sv
// ----------------------------------------------------------------------------
// sseg_queue
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sseg_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sseg_pkg::entry_t    push_data,
  input  logic                pop,
  output sseg_pkg::entry_t    head,
  output sseg_pkg::q_status_t q_status
);
  import sseg_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) slots[wr_ptr] <= push_data;
  end

  assign head               = slots[rd_ptr];
  assign q_status.full      = (count == 2'd2);
  assign q_status.not_empty = (count != 2'd0);

endmodule

// File: src/sseg_back.sv
// ----------------------------------------------------------------------------
// sseg_back
// Byte sequencer: walks the queue head and emits one framed byte per cycle while the queue is not empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sseg_back (
  input  logic                clk,
  input  logic                rst,
  input  sseg_pkg::entry_t    head,
  input  sseg_pkg::q_status_t q_status,
  output logic                pop,
  output logic                valid,
  output logic [7:0]          byte_value,
  output logic                start_before,
  output logic                stop_after,
  output logic                last
);
  import sseg_pkg::*;

  logic [2:0] idx, idx_next;
  logic [1:0] grp, grp_next;
  logic [7:0] b;
  logic       sb, sa, lst;
  logic [1:0] place;
  logic [2:0] seg_idx;

  assign place   = (head.kind == K_DIGIT) ? head.place : grp;
  assign seg_idx = idx - 3'd2;

  always_comb begin
    b        = 8'h00;
    sb       = 1'b0;
    sa       = 1'b0;
    lst      = 1'b0;
    idx_next = idx + 3'd1;
    grp_next = grp;
    unique case (head.kind)
      K_ALL4: begin
        case (idx)
          3'd0:    begin b = BYTE_AUTO_INC; sb = 1'b1; sa = 1'b1; end
          3'd1:    begin b = BYTE_ADDR;     sb = 1'b1;            end
          default: begin
            b   = head.seg[seg_idx[1:0]];
            sa  = (idx == 3'd5);
            lst = (idx == 3'd5);
          end
        endcase
      end
      K_SINGLE: begin
        b   = head.seg[0];
        sb  = 1'b1;
        sa  = 1'b1;
        lst = 1'b1;
      end
      default: begin
        case (idx)
          3'd0:    begin b = BYTE_FIXED; sb = 1'b1; sa = 1'b1; end
          3'd1:    begin b = BYTE_ADDR | {6'd0, place}; sb = 1'b1; end
          default: begin
            b   = (head.kind == K_DIGIT) ? head.seg[0] : head.seg[grp];
            sa  = 1'b1;
            lst = (head.kind == K_DIGIT) || (grp == 2'd3);
            // next digit write
            idx_next = 3'd0;
            grp_next = grp + 2'd1;
          end
        endcase
      end
    endcase
    if (lst) begin
      idx_next = 3'd0;
      grp_next = 2'd0;
    end
  end

  assign pop = q_status.not_empty && lst;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= 3'd0;
      grp   <= 2'd0;
      valid <= 1'b0;
    end else begin
      valid <= q_status.not_empty;
      if (q_status.not_empty) begin
        idx <= idx_next;
        grp <= grp_next;
      end
    end
    byte_value   <= b;
    start_before <= sb;
    stop_after   <= sa;
    last         <= lst;
  end

endmodule

// File: src/seven_segment_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// seven_segment_frame_encoder_core
// Turns display commands into framed byte sequences for a four-digit
// seven-segment controller chip.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its bytes come out
// one per clock on byte_value, each marked by valid for exactly one cycle,
// with start_before, stop_after and last alongside; the receiver must take
// them as they come. The back sequencer emits one byte per cycle while the
// queue holds a command: 1 byte for brightness, 3 for a digit write, 6 for
// clear or an out-of-range tenths value, 12 for a number or tenths value.
// Numbers and tenths values pass through the front converter digit by digit,
// tens and ones last, with busy high meanwhile; this overlaps with the byte
// output of earlier commands. Busy is also high while the two-entry command
// queue is full. An accepted command is first written into the queue, and
// the back sequencer then registers its first byte together with valid.
// Invalid digit writes and unknown commands produce no bytes.
`timescale 1ns / 1ps

module seven_segment_frame_encoder_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic [3:0]         brightness_level,
  input  logic [2:0]         position,
  input  logic [3:0]         digit_value,
  input  logic               dot,
  input  logic signed [16:0] number,
  output logic               valid,
  output logic [7:0]         byte_value,
  output logic               start_before,
  output logic               stop_after,
  output logic               last
);
  import sseg_pkg::*;

  q_status_t q_status;
  entry_t    push_data;
  entry_t    head;
  logic      push;
  logic      pop;

  sseg_front u_front (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .cmd              (cmd),
    .brightness_level (brightness_level),
    .position         (position),
    .digit_value      (digit_value),
    .dot              (dot),
    .number           (number),
    .q_status         (q_status),
    .push             (push),
    .push_data        (push_data)
  );

  sseg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  sseg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .valid        (valid),
    .byte_value   (byte_value),
    .start_before (start_before),
    .stop_after   (stop_after),
    .last         (last)
  );

endmodule
